// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the recency list; every check runs on i_clk with reset as disable.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/lru_rl_pkg.sv -----
package lru_rl_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PAGE_W  = 16;
    localparam int FRAME_W = 8;
    localparam int OP_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_REMOVE = 2'd2
    } t_op;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    typedef struct packed {
        logic load;
        logic pop;
        logic remove;
    } t_cell_ctrl;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [FRAME_W-1:0] oldest_frame;
        logic [PAGE_W-1:0]  oldest_page;
        logic               oldest_valid;
        logic [FRAME_W-1:0] removed_frame;
        logic               ok;
    } t_result;

endpackage

// ----- hw/rtl/lru_rl_cell.sv -----
module lru_rl_cell
    import lru_rl_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_valid,
    input  logic [PAGE_W-1:0] i_key,
    input  t_entry            i_push,
    input  t_entry            i_next,
    input  logic              i_hit_in,
    output logic              o_hit_out,
    output logic              o_first,
    output t_entry            o_data,
    output t_entry            o_data_next
);

    t_entry r_data;
    t_entry n_data;
    logic   w_match;

    assign w_match = i_valid && (r_data.page == i_key);
    assign o_hit_out = i_hit_in | w_match;
    assign o_first = w_match & ~i_hit_in;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_push;
        end else if (i_ctrl.pop) begin
            n_data = i_next;
        end else if (i_ctrl.remove && (i_hit_in || w_match)) begin
            // close the gap left by the oldest match
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_data_next = n_data;

endmodule

// ----- hw/rtl/lru_recency_list_unit.sv -----
// Recency list of up to DEPTH page/frame entries, oldest first.
// Input stream: one word per operation; tuser carries the operation
// (push newest, pop oldest, remove oldest entry with a matching page),
// tdata the page number and the frame index to push.
// Output stream: one result word per operation with the ok flag, the frame
// of a removed entry, the oldest entry after the operation and the count.
// Each entry lives in one cell of a row; cell 0 holds the oldest. All cells
// compare against the page in parallel; on pop all cells, and on remove the oldest
// match and all younger cells, take their younger neighbour's word in the same cycle.
// The result word is registered when the operation word is accepted.
// Throughput: one operation per cycle while the receiver takes each result,
// as the cell row and the count register update together on each accepted word.
// Reset empties the list and the output register; cell contents are not
// cleared, the count alone marks which cells hold entries.
// When the receiver stalls, the result holds and input is taken only once
// the output register is free or drains in the same cycle.
module lru_recency_list_unit
    import lru_rl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // page_number[15:0], frame_index[23:16]
    input  logic [1:0]  i_s_tuser,   // operation[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // ok[0], removed_frame[8:1], oldest_valid[9],
                                     // oldest_page[25:10], oldest_frame[33:26],
                                     // entry_count[38:34], zero pad
);

    `include "assert_macros.svh"

    logic             r_out_valid;
    logic             n_out_valid;
    t_result          r_res;
    t_result          n_res;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    logic               w_acc;
    t_op                w_op;
    t_entry             w_push;
    logic [PAGE_W-1:0]  w_key;
    t_cell_ctrl         w_ctrl [DEPTH];
    t_entry             w_data [DEPTH];
    t_entry             w_data_next [DEPTH];
    logic [DEPTH:0]     w_hit;
    logic [DEPTH-1:0]   w_first;
    logic [FRAME_W-1:0] w_hit_frame;
    logic               w_found;
    logic               w_ok;

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign w_acc = i_s_tvalid & o_s_tready;
    assign w_op = t_op'(i_s_tuser);
    assign w_key = i_s_tdata[PAGE_W-1:0];
    assign w_push.page = i_s_tdata[PAGE_W-1:0];
    assign w_push.frame = i_s_tdata[PAGE_W+FRAME_W-1:PAGE_W];
    assign w_hit[0] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        assign w_ctrl[gi].load = w_acc && (w_op == OP_PUSH) && (r_count == CNT_W'(gi));
        assign w_ctrl[gi].pop = w_acc && (w_op == OP_POP) && (r_count != '0);
        assign w_ctrl[gi].remove = w_acc && (w_op == OP_REMOVE);

        lru_rl_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl[gi]),
            .i_valid     (r_count > CNT_W'(gi)),
            .i_key       (w_key),
            .i_push      (w_push),
            .i_next      ((gi == DEPTH - 1) ? w_data[gi] : w_data[(gi + 1) % DEPTH]),
            .i_hit_in    (w_hit[gi]),
            .o_hit_out   (w_hit[gi+1]),
            .o_first     (w_first[gi]),
            .o_data      (w_data[gi]),
            .o_data_next (w_data_next[gi])
        );
    end

    assign w_found = w_hit[DEPTH];

    always_comb begin
        w_hit_frame = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit_frame = w_hit_frame | (w_data[i].frame & {FRAME_W{w_first[i]}});
        end
    end

    always_comb begin
        case (w_op)
            OP_PUSH:   w_ok = (r_count != CNT_W'(DEPTH));
            OP_POP:    w_ok = (r_count != '0);
            OP_REMOVE: w_ok = w_found;
            default:   w_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_acc && w_ok) begin
            if (w_op == OP_PUSH) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_res.ok = w_ok;
        n_res.removed_frame = (w_op == OP_REMOVE && w_found) ? w_hit_frame : '0;
        n_res.oldest_valid = (n_count != '0);
        n_res.oldest_page = n_res.oldest_valid ? w_data_next[0].page : '0;
        n_res.oldest_frame = n_res.oldest_valid ? w_data_next[0].frame : '0;
        n_res.count = n_count;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_acc) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_count <= n_count;
        end
    end

    // hold the result word while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_res <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata = {1'b0, r_res.count, r_res.oldest_frame, r_res.oldest_page,
                        r_res.oldest_valid, r_res.removed_frame, r_res.ok};

    `ASSERT_IMP(a_count_range, 1'b1, r_count <= CNT_W'(DEPTH))
    `ASSERT_NXT(a_push_grows, w_acc && (w_op == OP_PUSH) && (r_count != CNT_W'(DEPTH)),
        r_count == $past(r_count) + CNT_W'(1))
    `ASSERT_IMP(a_oldest_matches_count, r_out_valid,
        r_res.oldest_valid == (r_res.count != '0))
    `ASSERT_IMP(a_removed_only_on_ok, r_out_valid && !r_res.ok, r_res.removed_frame == '0)

endmodule

// ----- test/tb_lru_recency_list_unit.sv -----
`timescale 1ns / 1ps

module tb_lru_recency_list_unit;
    import lru_rl_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int              STALL_LIMIT = 2000;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } list_op_t;

    typedef struct {
        t_result res;
        longint  accepted_at;
    } awaited_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;   // page_number[15:0], frame_index[23:16]
    logic [1:0]  i_s_tuser = '0;   // operation[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // ok[0], removed_frame[8:1], oldest_valid[9],
                                   // oldest_page[25:10], oldest_frame[33:26],
                                   // entry_count[38:34], zero pad

    list_op_t queued_ops[$];
    list_op_t in_flight;
    t_entry   held_entries[$];
    awaited_t awaited_results[$];
    int       error_count = 0;
    int       src_pause = 0;
    int       src_calm = 0;
    int       snk_pause = 0;
    int       snk_calm = 0;
    int       idle_cycles = 0;

    lru_recency_list_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Apply one operation to the oldest-first shadow list and return its result.
    function automatic t_result apply_list_op(input list_op_t cmd);
        t_result r;
        t_entry  e;
        int      hit;
        r   = '0;
        hit = -1;
        case (cmd.op)
            OP_PUSH: begin
                if (held_entries.size() < DEPTH) begin
                    e.page  = cmd.page;
                    e.frame = cmd.frame;
                    held_entries.push_back(e);
                    r.ok = 1'b1;
                end
            end
            OP_POP: begin
                if (held_entries.size() > 0) begin
                    void'(held_entries.pop_front());
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                foreach (held_entries[i])
                    if (hit < 0 && held_entries[i].page == cmd.page)
                        hit = i;
                if (hit >= 0) begin
                    r.removed_frame = held_entries[hit].frame;
                    held_entries.delete(hit);
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        if (held_entries.size() > 0) begin
            r.oldest_valid = 1'b1;
            r.oldest_page  = held_entries[0].page;
            r.oldest_frame = held_entries[0].frame;
        end
        r.count = CNT_W'(held_entries.size());
        return r;
    endfunction

    // Mostly no or short pauses, a few long ones, and calm stretches with none.
    function automatic int draw_pause(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
            calm_left = $urandom_range(20, 60);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Small pool so removes hit and duplicates occur; some extremes and wide values.
    function automatic logic [PAGE_W-1:0] pick_page();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return PAGE_W'($urandom_range(0, 7));
        if (r < 85)
            return (r % 2) ? '1 : '0;
        return PAGE_W'($urandom_range(0, 65535));
    endfunction

    task automatic add_op(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                          input logic [FRAME_W-1:0] frame);
        list_op_t c;
        c.op    = op;
        c.page  = page;
        c.frame = frame;
        queued_ops.push_back(c);
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Driver: hold a word until taken, then pause or load the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                awaited_results.push_back('{apply_list_op(in_flight), $time});
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (src_pause > 0) begin
                    src_pause--;
                    i_s_tvalid <= 1'b0;
                end else if (queued_ops.size() > 0) begin
                    in_flight = queued_ops.pop_front();
                    i_s_tdata <= {in_flight.frame, in_flight.page};
                    i_s_tuser <= in_flight.op;
                    i_s_tvalid <= 1'b1;
                    src_pause = draw_pause(src_calm);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (snk_pause > 0) begin
            snk_pause--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            snk_pause = draw_pause(snk_calm);
        end
    end

    // Monitor: match each result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_result  got;
        awaited_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[38:0]);
            if (awaited_results.size() == 0 || awaited_results[0].accepted_at >= $time) begin
                report_mismatch("unexpected result", o_m_tdata, '0);
            end else begin
                want = awaited_results.pop_front();
                if (got.ok !== want.res.ok)
                    report_mismatch("ok", 40'(got.ok), 40'(want.res.ok));
                if (got.removed_frame !== want.res.removed_frame)
                    report_mismatch("removed_frame", 40'(got.removed_frame),
                                    40'(want.res.removed_frame));
                if (got.oldest_valid !== want.res.oldest_valid)
                    report_mismatch("oldest_valid", 40'(got.oldest_valid),
                                    40'(want.res.oldest_valid));
                if (got.oldest_page !== want.res.oldest_page)
                    report_mismatch("oldest_page", 40'(got.oldest_page),
                                    40'(want.res.oldest_page));
                if (got.oldest_frame !== want.res.oldest_frame)
                    report_mismatch("oldest_frame", 40'(got.oldest_frame),
                                    40'(want.res.oldest_frame));
                if (got.count !== want.res.count)
                    report_mismatch("entry_count", 40'(got.count), 40'(want.res.count));
                if (o_m_tdata[39] !== 1'b0)
                    report_mismatch("pad", 40'(o_m_tdata[39]), '0);
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_lru_recency_list_unit: done, errors");
                $finish;
            end
        end
    end

    initial begin
        int              r;
        int              n;
        bit              filling;
        logic [OP_W-1:0] op;

        // Empty list: pop, remove and the reserved code all fail.
        add_op(OP_POP, 16'h0000, 8'h00);
        add_op(OP_REMOVE, 16'h0000, 8'h00);
        add_op(OP_RESERVED, 16'hFFFF, 8'hFF);
        // Field extremes and a duplicated page.
        add_op(OP_PUSH, 16'h0000, 8'h00);
        add_op(OP_PUSH, 16'hFFFF, 8'hFF);
        add_op(OP_PUSH, 16'h1234, 8'hAA);
        add_op(OP_PUSH, 16'h1234, 8'h55);
        // Only the older duplicate goes; the gap closes.
        add_op(OP_REMOVE, 16'h1234, 8'h00);
        // Fill to capacity, then push once more.
        for (int i = 0; i < DEPTH - 3; i++)
            add_op(OP_PUSH, PAGE_W'(16'h0100 + i), FRAME_W'(8'h10 + i));
        add_op(OP_PUSH, 16'hBEEF, 8'h77);
        add_op(OP_REMOVE, 16'hCAFE, 8'h00);
        add_op(OP_REMOVE, 16'hFFFF, 8'h00);
        add_op(OP_RESERVED, 16'h0000, 8'h00);
        add_op(OP_POP, 16'h0000, 8'h00);

        // Alternate fill-biased and drain-biased blocks so the list swings
        // between empty and full.
        for (int blk = 0; blk < 12; blk++) begin
            filling = (blk % 2 == 0);
            n = $urandom_range(30, 50);
            repeat (n) begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    op = OP_RESERVED;
                else if (filling)
                    op = (r < 75) ? OP_PUSH : ((r < 87) ? OP_POP : OP_REMOVE);
                else
                    op = (r < 25) ? OP_PUSH : ((r < 55) ? OP_POP : OP_REMOVE);
                add_op(op, pick_page(), FRAME_W'($urandom_range(0, 255)));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_ops.size() != 0 || i_s_tvalid)
            @(posedge i_clk);
        while (awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (error_count == 0)
            $display("tb_lru_recency_list_unit: done, clean");
        else
            $display("tb_lru_recency_list_unit: done, errors");
        $finish;
    end

endmodule
